>>> rtl/core/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// shared constants, types and the cordic angle table for the attitude filter
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    // cordic x/y width: magnitude up to ~46341*256*1.65, numerator 2^23
    localparam int CW = 27;
    localparam int ZW = 22;
    // sqrt radicand is (2^31) << 16 at most: 48 bits, root 24 bits
    localparam int SQ_W = 48;
    localparam int RT_W = 24;
    localparam int SQ_STEPS = SQ_W / 2;

    localparam logic [4:0] REG_GAIN  = 5'd0;
    localparam logic [4:0] REG_ALPHA = 5'd1;

    localparam logic [23:0] GAIN_RESET  = 24'd81920;
    localparam logic [15:0] ALPHA_RESET = 16'd64225;

    typedef struct packed {
        logic load;      // latch sample, start pitch magnitude
        logic sel_roll;  // which axis the shared units work on
        logic sqrt_init;
        logic sqrt_step;
        logic cord_init;
        logic cord_step;
        logic fuse_mul;
        logic fuse_sum;
        logic fuse_mix;
        logic fuse_sat;
    } t_cmd;

    function automatic logic [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] v;
        case (i)
            0: v = 22'd737280;  1: v = 22'd435242;  2: v = 22'd229970;
            3: v = 22'd116736;  4: v = 22'd58595;   5: v = 22'd29326;
            6: v = 22'd14667;   7: v = 22'd7334;    8: v = 22'd3667;
            9: v = 22'd1833;    10: v = 22'd917;    11: v = 22'd458;
            12: v = 22'd229;    13: v = 22'd115;    14: v = 22'd57;
            15: v = 22'd29;     16: v = 22'd14;     17: v = 22'd7;
            18: v = 22'd4;      19: v = 22'd2;      20: v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/cfa_if.sv
// ----------------------------------------------------------------------------
// cfa_in_if / cfa_out_if
// valid/ready channels for imu samples and fused angles
// ----------------------------------------------------------------------------
interface cfa_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                    output ready);
endinterface

interface cfa_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pitch_out;
    logic signed [23:0] roll_out;
    modport source (output valid, pitch_out, roll_out, input ready);
    modport sink   (input valid, pitch_out, roll_out, output ready);
endinterface

>>> rtl/core/cfa_datapath.sv
// ----------------------------------------------------------------------------
// cfa_datapath
// shared sqrt, cordic and blend units plus the stored angles
// ----------------------------------------------------------------------------
module cfa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfa_pkg::t_cmd      i_cmd,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_az,
    input  logic signed [15:0] i_gx,
    input  logic signed [15:0] i_gy,
    input  logic [23:0]        i_gain,
    input  logic [15:0]        i_alpha,
    output logic signed [23:0] o_pitch,
    output logic signed [23:0] o_roll
);
    localparam int CW = cfa_pkg::CW;
    localparam int ZW = cfa_pkg::ZW;

    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic signed [23:0] r_pitch, r_roll;

    // sqrt unit (bit pair per cycle)
    logic [cfa_pkg::SQ_W-1:0] r_rem;
    logic [cfa_pkg::SQ_W-1:0] r_root;
    logic [cfa_pkg::SQ_W-1:0] r_bit;
    logic [cfa_pkg::SQ_W-1:0] sq_trial;

    // cordic
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [cfa_pkg::STEP_W-1:0] r_i;
    logic r_zero;

    // blend
    logic signed [41:0] r_delta_p;
    logic signed [24:0] r_gang;
    logic signed [42:0] r_ma, r_mb;
    logic signed [42:0] r_mix;

    logic signed [16:0] sel_num, sel_a, sel_b;
    logic [31:0] sumsq;

    always_comb begin
        sel_a   = i_cmd.sel_roll ? 17'(r_ay) : 17'(r_ax);
        sel_b   = 17'(r_az);
        sel_num = i_cmd.sel_roll ? -17'(r_ax) : 17'(r_ay);
        sumsq   = 32'(sel_a) * 32'(sel_a) + 32'(sel_b) * 32'(sel_b);
        sq_trial = r_root + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_roll  <= '0;
        end else if (i_cmd.fuse_sat) begin
            if (i_cmd.sel_roll) r_roll <= (r_mix > 43'sd8388607) ? 24'sh7fffff :
                                (r_mix < -43'sd8388608) ? 24'sh800000 : r_mix[23:0];
            else r_pitch <= (r_mix > 43'sd8388607) ? 24'sh7fffff :
                            (r_mix < -43'sd8388608) ? 24'sh800000 : r_mix[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_ax; r_ay <= i_ay; r_az <= i_az; r_gx <= i_gx; r_gy <= i_gy;
        end
        if (i_cmd.sqrt_init) begin
            r_rem  <= {sumsq, 16'd0};
            r_root <= '0;
            r_bit  <= 48'd1 << (cfa_pkg::SQ_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= sq_trial) begin
                r_rem  <= r_rem - sq_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.cord_init) begin
            r_x    <= CW'(r_root[cfa_pkg::RT_W-1:0]);
            r_y    <= CW'(sel_num) <<< 8;
            r_z    <= '0;
            r_i    <= '0;
            r_zero <= (r_root == '0) && (sel_num == '0);
        end else if (i_cmd.cord_step) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + $signed(cfa_pkg::atan_entry(r_i));
            end else begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - $signed(cfa_pkg::atan_entry(r_i));
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.cord_step) begin
            r_delta_p <= (i_cmd.sel_roll ? 42'(r_gy) : 42'(r_gx))
                         * $signed({18'd0, i_gain});
        end
        if (i_cmd.fuse_mul) begin
            r_gang <= (i_cmd.sel_roll ? 25'(r_roll) : 25'(r_pitch))
                      + 25'((r_delta_p + 42'sd32768) >>> 16);
        end
        if (i_cmd.fuse_sum) begin
            r_ma <= 43'(r_gang) * $signed({27'd0, i_alpha});
            r_mb <= (r_zero ? 43'sd0 : 43'(r_z)) * $signed(43'd65536 - 43'(i_alpha));
        end
        if (i_cmd.fuse_mix) r_mix <= (r_ma + r_mb + 43'sd32768) >>> 16;
    end

    assign o_pitch = r_pitch;
    assign o_roll  = r_roll;
endmodule

>>> rtl/core/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// sequencer: sqrt, cordic and blend for pitch then roll, then output word
// ----------------------------------------------------------------------------
module cfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cfa_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQI, S_SQ, S_CI, S_CORD, S_MUL, S_SUM, S_MIX, S_SAT
    } t_state;

    t_state r_state;
    logic   r_roll, r_out_valid;
    logic [4:0] r_cnt;

    always_comb begin
        o_cmd = '0;
        o_cmd.sel_roll = r_roll;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid && !r_out_valid;
        unique case (r_state)
            S_SQI:  o_cmd.sqrt_init = 1'b1;
            S_SQ:   o_cmd.sqrt_step = 1'b1;
            S_CI:   o_cmd.cord_init = 1'b1;
            S_CORD: o_cmd.cord_step = 1'b1;
            S_MUL:  o_cmd.fuse_mul  = 1'b1;
            S_SUM:  o_cmd.fuse_sum  = 1'b1;
            S_MIX:  o_cmd.fuse_mix  = 1'b1;
            S_SAT:  o_cmd.fuse_sat  = 1'b1;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_roll <= 1'b0; r_out_valid <= 1'b0; r_cnt <= '0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_cmd.load) begin r_state <= S_SQI; r_roll <= 1'b0; end
                S_SQI:  begin r_state <= S_SQ; r_cnt <= '0; end
                S_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(cfa_pkg::SQ_STEPS - 1)) r_state <= S_CI;
                end
                S_CI:   begin r_state <= S_CORD; r_cnt <= '0; end
                S_CORD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(cfa_pkg::CORDIC_STEPS - 1)) r_state <= S_MUL;
                end
                S_MUL:  r_state <= S_SUM;
                S_SUM:  r_state <= S_MIX;
                S_MIX:  r_state <= S_SAT;
                S_SAT: begin
                    if (r_roll) begin
                        r_state <= S_IDLE; r_out_valid <= 1'b1;
                    end else begin
                        r_roll <= 1'b1; r_state <= S_SQI;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/complementary_filter_attitude_top.sv
// ----------------------------------------------------------------------------
// complementary_filter_attitude_top
// complementary pitch/roll filter over raw accelerometer and gyro words
// ----------------------------------------------------------------------------
// The sample is latched at accept; then pitch and roll each run a square-root
// init state, a bit-pair square root, a cordic init state, cordic vectoring
// and the blend states mul, sum, mix and sat on the same shared units. The
// next word is taken once the previous output word has been accepted.
module complementary_filter_attitude_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfa_in_if.sink      in_ch,
    cfa_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    logic [23:0] r_gain;
    logic [15:0] r_alpha;
    cfa_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= cfa_pkg::GAIN_RESET;
            r_alpha <= cfa_pkg::ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfa_pkg::REG_GAIN:  r_gain  <= i_cfg_data;
                cfa_pkg::REG_ALPHA: r_alpha <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    cfa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_cmd(cmd)
    );

    cfa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_ax(in_ch.accel_x), .i_ay(in_ch.accel_y), .i_az(in_ch.accel_z),
        .i_gx(in_ch.gyro_x), .i_gy(in_ch.gyro_y),
        .i_gain(r_gain), .i_alpha(r_alpha),
        .o_pitch(out_ch.pitch_out), .o_roll(out_ch.roll_out)
    );
endmodule

>>> test/cfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_checker
// watches the sample and angle channels, predicts fused pitch/roll from each
// accepted sample and compares every accepted output word field by field
// ----------------------------------------------------------------------------
module cfa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_ax,
    input  logic [15:0] i_ay,
    input  logic [15:0] i_az,
    input  logic [15:0] i_gx,
    input  logic [15:0] i_gy,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_pitch,
    input  logic [23:0] i_roll,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_words
);
    typedef struct packed {
        logic signed [23:0] pitch;
        logic signed [23:0] roll;
    } t_angles;

    t_angles            angle_q[$];
    logic [23:0]        step_gain;
    logic [15:0]        alpha;
    logic signed [23:0] pitch_st;
    logic signed [23:0] roll_st;

    const longint atan_deg[24] = '{737280, 435242, 229970, 116736, 58595, 29326,
        14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};

    function automatic longint floor_sqrt(longint n);
        longint root;
        longint b;
        root = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    function automatic longint accel_tilt(longint num, longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = floor_sqrt((a * a + b * b) << 16);
        y = num * 256;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < cfa_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_deg[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_deg[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [23:0] blend_angle(longint stored, longint rate,
                                                       longint acc);
        longint gyro_ang;
        longint a;
        longint mix;
        a = longint'(alpha);
        gyro_ang = stored + ((rate * longint'(step_gain) + 32768) >>> 16);
        mix = (a * gyro_ang + (65536 - a) * acc + 32768) >>> 16;
        if (mix > 8388607) mix = 8388607;
        if (mix < -8388608) mix = -8388608;
        return mix[23:0];
    endfunction

    always @(posedge i_clk) begin
        longint ax;
        longint ay;
        longint az;
        t_angles got;
        t_angles want;
        if (!i_rst_n) begin
            step_gain <= cfa_pkg::GAIN_RESET;
            alpha     <= cfa_pkg::ALPHA_RESET;
            pitch_st  <= '0;
            roll_st   <= '0;
            angle_q.delete();
            o_errors  <= 0;
            o_words   <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx == cfa_pkg::REG_GAIN) step_gain <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == cfa_pkg::REG_ALPHA) alpha <= i_cfg_data[15:0];
            if (i_in_valid && i_in_ready) begin
                ax = longint'($signed(i_ax));
                ay = longint'($signed(i_ay));
                az = longint'($signed(i_az));
                want.pitch = blend_angle(pitch_st, longint'($signed(i_gx)),
                                         accel_tilt(ay, ax, az));
                want.roll  = blend_angle(roll_st, longint'($signed(i_gy)),
                                         accel_tilt(-ax, ay, az));
                pitch_st <= want.pitch;
                roll_st  <= want.roll;
                angle_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got.pitch = i_pitch;
                got.roll  = i_roll;
                o_words <= o_words + 1;
                if (angle_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected word p=%0d r=%0d",
                                                got.pitch, got.roll);
                end else begin
                    want = angle_q.pop_front();
                    if (got != want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch pitch exp %0d got %0d, roll exp %0d got %0d",
                                     want.pitch, got.pitch, want.roll, got.roll);
                    end
                end
            end
        end
    end

    assign o_pending = angle_q.size();

endmodule

>>> test/complementary_filter_attitude_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_filter_attitude_top_tb
// directed and random imu samples across several gain/alpha settings, random
// idling on both channels, checked by cfa_checker
// ----------------------------------------------------------------------------
module complementary_filter_attitude_top_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_idx;
    logic [23:0] cfg_data;
    int          errors;
    int          pending;
    int          words;
    int          cycles;
    int          idle_pct;
    int          sent;

    cfa_in_if  in_ch();
    cfa_out_if out_ch();

    complementary_filter_attitude_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    cfa_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_ax(in_ch.accel_x), .i_ay(in_ch.accel_y), .i_az(in_ch.accel_z),
        .i_gx(in_ch.gyro_x), .i_gy(in_ch.gyro_y),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_pitch(out_ch.pitch_out), .i_roll(out_ch.roll_out),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_words(words)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // output side stalls at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // valid stays high after the accept; the next call replaces or drops it, a drain drops it
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] gx,
                               input logic [15:0] gy);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= ax;
        in_ch.accel_y <= ay;
        in_ch.accel_z <= az;
        in_ch.gyro_x  <= gx;
        in_ch.gyro_y  <= gy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_words();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [4:0] idx, input logic [23:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run(input int n);
        for (int k = 0; k < n; k++)
            send_sample(rand_axis(), rand_axis(), rand_axis(), 16'($urandom),
                        16'($urandom));
    endtask

    initial begin
        cycles        = 0;
        sent          = 0;
        idle_pct      = 9;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = cfa_pkg::REG_GAIN;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        in_ch.gyro_x  = '0;
        in_ch.gyro_y  = '0;
        out_ch.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, full negative x, extremes, axis tilts
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h0000, 16'h4000, 16'h0000, 16'h0001, 16'hffff);
        send_sample(16'h0000, 16'hc000, 16'h0000, 16'hffff, 16'h0001);
        send_sample(16'h4000, 16'h0000, 16'h4000, 16'h1234, 16'hedcb);
        send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000);
        send_sample(16'h0001, 16'hffff, 16'h0000, 16'h5555, 16'haaaa);
        drain_words();

        // extreme gain and alpha=0: pure accelerometer
        write_reg(cfa_pkg::REG_GAIN, 24'hffffff);
        write_reg(cfa_pkg::REG_ALPHA, 16'h0000);
        random_run(300);
        drain_words();
        // alpha max, big gain: gyro integrates toward saturation
        write_reg(cfa_pkg::REG_ALPHA, 16'hffff);
        for (int k = 0; k < 40; k++)
            send_sample(rand_axis(), rand_axis(), rand_axis(), 16'h7fff, 16'h8000);
        for (int k = 0; k < 40; k++)
            send_sample(rand_axis(), rand_axis(), rand_axis(), 16'h8000, 16'h7fff);
        drain_words();
        // zero gain, unused index ignored
        write_reg(cfa_pkg::REG_GAIN, 24'h000000);
        write_reg(5'd7, 24'h123456);
        write_reg(cfa_pkg::REG_ALPHA, 16'h8000);
        random_run(300);
        drain_words();
        // random settings, one stretch without idling
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(cfa_pkg::REG_GAIN, 24'($urandom));
            write_reg(cfa_pkg::REG_ALPHA, 16'($urandom));
            idle_pct = (ph == 2) ? 0 : 9;
            random_run(200);
            drain_words();
        end
        idle_pct = 9;
        write_reg(cfa_pkg::REG_GAIN, cfa_pkg::GAIN_RESET);
        write_reg(cfa_pkg::REG_ALPHA, cfa_pkg::ALPHA_RESET);
        random_run(100);
        drain_words();

        $display("covered %0d samples, %0d output words, gain/alpha extremes and random",
                 sent, words);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
